>>> rtl/core/password_door_lock_controller_unit_defines.svh
// Assertion macros shared by the door lock controller RTL.
// No dependencies; included by files that carry concurrent assertions.
// Define ASSERT_OFF to compile the assertions out.
`ifndef PASSWORD_DOOR_LOCK_CONTROLLER_UNIT_DEFINES_SVH
`define PASSWORD_DOOR_LOCK_CONTROLLER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked on every rising clk edge, off while in reset
`define PDLC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Overlapping implication, off while in reset
`define PDLC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define PDLC_ASSERT(lbl, prop, msg)
`define PDLC_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/core/pdlc_pkg.sv
// Package for the door lock controller: phase codes, register indexes,
// reset values, sizes and the structs passed between modules. No dependencies.
package pdlc_pkg;

    // Longest code kept; longer entries drop the extra bytes
    localparam int MAX_LEN   = 16;
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int IDX_W     = $clog2(MAX_LEN);
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_OPT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_OPT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ATT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_TICKS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_TICKS = 3'd6;

    // Register reset values
    localparam logic [7:0] RST_CHANGE_OPT  = 8'd1;
    localparam logic [7:0] RST_OPEN_OPT    = 8'd2;
    localparam logic [7:0] RST_END_MARKER  = 8'd35;
    localparam logic [2:0] RST_MAX_ATT     = 3'd3;
    localparam logic [7:0] RST_MOVE_TICKS  = 8'd15;
    localparam logic [7:0] RST_HOLD_TICKS  = 8'd3;
    localparam logic [7:0] RST_ALARM_TICKS = 8'd60;

    // Saturation point of the attempt counter
    localparam logic [2:0] ATT_SAT = 3'd7;

    // Motor commands
    localparam logic [1:0] MOTOR_STOP  = 2'd0;
    localparam logic [1:0] MOTOR_OPEN  = 2'd1;
    localparam logic [1:0] MOTOR_CLOSE = 2'd2;

    typedef enum logic [3:0] {
        PH_ENROLL_A     = 4'd0,
        PH_ENROLL_B     = 4'd1,
        PH_OPTION       = 4'd2,
        PH_CHECK_CHANGE = 4'd3,
        PH_CHECK_OPEN   = 4'd4,
        PH_DOOR_OPEN    = 4'd5,
        PH_DOOR_HOLD    = 4'd6,
        PH_DOOR_CLOSE   = 4'd7,
        PH_ALARM        = 4'd8
    } phase_t;

    // Configuration register file contents
    typedef struct packed {
        logic [7:0] change_option_code;
        logic [7:0] open_option_code;
        logic [7:0] end_marker;
        logic [2:0] max_attempts;
        logic [7:0] move_ticks;
        logic [7:0] hold_ticks;
        logic [7:0] alarm_ticks;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic       busy_res;
        logic       buzzer_on;
        logic [1:0] motor_drive;
        logic       reply_match;
        logic       reply_valid;
    } result_t;

endpackage

>>> rtl/core/pdlc_fsm.sv
// Door lock state machine: phase, stored code, entry compare and tick timer.
// Depends on pdlc_pkg. Updates its state once per step_en; result is combinational.
module pdlc_fsm
    import pdlc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic       command,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output result_t    result
);

    localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(MAX_LEN);

    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] saved_len_reg, saved_len_next;
    logic [LEN_W-1:0] entry_len_reg, entry_len_next;
    logic             match_reg, match_next;
    logic [2:0]       att_reg, att_next;
    logic [7:0]       tick_reg, tick_next;

    // Stored code, one byte per entry; the byte for the next compare is read ahead
    logic [7:0]       saved_code_mem [MAX_LEN];
    logic             code_we;
    logic [IDX_W-1:0] code_waddr;
    logic [7:0]       code_rd_reg;

    logic             is_end;
    logic             cmp_room;
    logic             cmp_bad;
    logic             entry_ok;
    logic [7:0]       tick_inc;
    logic [7:0]       tick_limit;
    logic             timed_out;
    logic [2:0]       att_inc;
    logic             reply_valid;
    logic             reply_match;

    // Entry compare helpers
    assign is_end   = (rx_byte == cfg.end_marker);
    assign cmp_room = (entry_len_reg < MAX_LEN_L);
    assign cmp_bad  = (entry_len_reg >= saved_len_reg) || (code_rd_reg != rx_byte);
    assign entry_ok = match_reg && (entry_len_reg == saved_len_reg);
    assign tick_inc = tick_reg + 8'd1;
    assign att_inc  = (att_reg < ATT_SAT) ? att_reg + 3'd1 : att_reg;

    // Limit of the current timed phase
    always_comb
    begin
        case (phase_reg)
            PH_DOOR_OPEN:  tick_limit = cfg.move_ticks;
            PH_DOOR_HOLD:  tick_limit = cfg.hold_ticks;
            PH_DOOR_CLOSE: tick_limit = cfg.move_ticks;
            PH_ALARM:      tick_limit = cfg.alarm_ticks;
            default:       tick_limit = cfg.alarm_ticks;
        endcase
    end
    assign timed_out = (tick_inc >= tick_limit);

    // Next state and reply for one item
    always_comb
    begin
        phase_next     = phase_reg;
        saved_len_next = saved_len_reg;
        entry_len_next = entry_len_reg;
        match_next     = match_reg;
        att_next       = att_reg;
        tick_next      = tick_reg;
        code_we        = 1'b0;
        code_waddr     = saved_len_reg[IDX_W-1:0];
        reply_valid    = 1'b0;
        reply_match    = 1'b0;

        if (command)
        begin
            // One-second tick: only timed phases count
            case (phase_reg)
                PH_DOOR_OPEN, PH_DOOR_HOLD, PH_DOOR_CLOSE, PH_ALARM:
                begin
                    if (timed_out)
                    begin
                        tick_next = 8'd0;
                        case (phase_reg)
                            PH_DOOR_OPEN: phase_next = PH_DOOR_HOLD;
                            PH_DOOR_HOLD: phase_next = PH_DOOR_CLOSE;
                            default:      phase_next = PH_OPTION;
                        endcase
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            // Link byte
            case (phase_reg)
                PH_ENROLL_A:
                begin
                    if (is_end)
                    begin
                        phase_next     = PH_ENROLL_B;
                        entry_len_next = '0;
                        match_next     = 1'b1;
                    end
                    else if (saved_len_reg < MAX_LEN_L)
                    begin
                        code_we        = 1'b1;
                        saved_len_next = saved_len_reg + LEN_W'(1);
                    end
                end
                PH_ENROLL_B, PH_CHECK_CHANGE, PH_CHECK_OPEN:
                begin
                    if (!is_end)
                    begin
                        if (cmp_room)
                        begin
                            if (cmp_bad) match_next = 1'b0;
                            entry_len_next = entry_len_reg + LEN_W'(1);
                        end
                    end
                    else
                    begin
                        reply_valid    = 1'b1;
                        reply_match    = entry_ok;
                        entry_len_next = '0;
                        match_next     = 1'b1;
                        if (phase_reg == PH_ENROLL_B)
                        begin
                            if (entry_ok)
                            begin
                                phase_next = PH_OPTION;
                            end
                            else
                            begin
                                phase_next     = PH_ENROLL_A;
                                saved_len_next = '0;
                            end
                        end
                        else if (entry_ok)
                        begin
                            if (phase_reg == PH_CHECK_CHANGE)
                            begin
                                phase_next     = PH_ENROLL_A;
                                saved_len_next = '0;
                            end
                            else
                            begin
                                phase_next = PH_DOOR_OPEN;
                                tick_next  = 8'd0;
                            end
                        end
                        else
                        begin
                            att_next = att_inc;
                            if (att_inc >= cfg.max_attempts)
                            begin
                                phase_next = PH_ALARM;
                                tick_next  = 8'd0;
                            end
                        end
                    end
                end
                PH_OPTION:
                begin
                    att_next       = 3'd0;
                    entry_len_next = '0;
                    match_next     = 1'b1;
                    // Change wins when both option codes are equal
                    if (rx_byte == cfg.change_option_code)
                    begin
                        phase_next = PH_CHECK_CHANGE;
                    end
                    else if (rx_byte == cfg.open_option_code)
                    begin
                        phase_next = PH_CHECK_OPEN;
                    end
                    else
                    begin
                        phase_next = PH_ALARM;
                        tick_next  = 8'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result item: reply for this item, status follows the phase after it
    always_comb
    begin
        result.reply_valid = reply_valid;
        result.reply_match = reply_match;
        case (phase_next)
            PH_DOOR_OPEN:  result.motor_drive = MOTOR_OPEN;
            PH_DOOR_CLOSE: result.motor_drive = MOTOR_CLOSE;
            default:       result.motor_drive = MOTOR_STOP;
        endcase
        result.buzzer_on = (phase_next == PH_ALARM);
        result.busy_res  = (phase_next == PH_DOOR_OPEN) || (phase_next == PH_DOOR_HOLD) ||
                           (phase_next == PH_DOOR_CLOSE) || (phase_next == PH_ALARM);
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ENROLL_A;
            saved_len_reg <= '0;
            entry_len_reg <= '0;
            match_reg     <= 1'b1;
            att_reg       <= 3'd0;
            tick_reg      <= 8'd0;
        end
        else if (step_en)
        begin
            phase_reg     <= phase_next;
            saved_len_reg <= saved_len_next;
            entry_len_reg <= entry_len_next;
            match_reg     <= match_next;
            att_reg       <= att_next;
            tick_reg      <= tick_next;
        end
    end

    // Stored code write port and read-ahead of the byte at the next entry index.
    // Enrollment writes only while the entry index is zero, and its closing end
    // marker step reloads entry zero, so the read-ahead never holds a stale byte.
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            if (code_we)
            begin
                saved_code_mem[code_waddr] <= rx_byte;
            end
            code_rd_reg <= saved_code_mem[entry_len_next[IDX_W-1:0]];
        end
    end

endmodule

>>> rtl/core/password_door_lock_controller_unit.sv
// An accepted item is held in the input register, its result in the result register.
// Throughput: one item per cycle unless the result slot stalls; the input and result
// registers form a two-stage pipeline, and the state machine steps once per item.
// Reset (rst_n low, asynchronous): configuration takes its default values,
// the lock waits for the first enrollment code, both channels empty.
// Depends on pdlc_pkg, pdlc_fsm and the assertion macro header.
`include "password_door_lock_controller_unit_defines.svh"

module password_door_lock_controller_unit
    import pdlc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    input  logic                 s_tuser,   // [0] command
    // Result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [0] reply_valid, [1] reply_match,
                                            // [3:2] motor_drive, [4] buzzer_on,
                                            // [5] busy_res, [7:6] zero
    // Configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic       in_cmd_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    step_result;
    logic       advance;

    // Pipeline control: step when an item waits and the result slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.change_option_code <= RST_CHANGE_OPT;
            cfg_reg.open_option_code   <= RST_OPEN_OPT;
            cfg_reg.end_marker         <= RST_END_MARKER;
            cfg_reg.max_attempts       <= RST_MAX_ATT;
            cfg_reg.move_ticks         <= RST_MOVE_TICKS;
            cfg_reg.hold_ticks         <= RST_HOLD_TICKS;
            cfg_reg.alarm_ticks        <= RST_ALARM_TICKS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CHANGE_OPT:  cfg_reg.change_option_code <= cfg_data;
                REG_OPEN_OPT:    cfg_reg.open_option_code   <= cfg_data;
                REG_END_MARKER:  cfg_reg.end_marker         <= cfg_data;
                REG_MAX_ATT:     cfg_reg.max_attempts       <= cfg_data[2:0];
                REG_MOVE_TICKS:  cfg_reg.move_ticks         <= cfg_data;
                REG_HOLD_TICKS:  cfg_reg.hold_ticks         <= cfg_data;
                REG_ALARM_TICKS: cfg_reg.alarm_ticks        <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // Lock state machine
    pdlc_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .command (in_cmd_reg),
        .rx_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.busy_res, out_reg.buzzer_on, out_reg.motor_drive,
                       out_reg.reply_match, out_reg.reply_valid};

    // Checks on the pipeline and result encoding
    `PDLC_ASSERT_IMPL(a_match_needs_reply, out_valid_reg && out_reg.reply_match,
        out_reg.reply_valid, "match reply without reply valid")
    `PDLC_ASSERT_IMPL(a_buzzer_is_busy, out_valid_reg && out_reg.buzzer_on,
        out_reg.busy_res && (out_reg.motor_drive == MOTOR_STOP), "buzzer outside alarm")
    `PDLC_ASSERT_IMPL(a_motor_is_busy, out_valid_reg && (out_reg.motor_drive != MOTOR_STOP),
        out_reg.busy_res && (out_reg.motor_drive != 2'd3), "motor runs while not busy")
    `PDLC_ASSERT_IMPL(a_ready_when_empty, !out_valid_reg, s_tready,
        "input stalled with empty result slot")
    `PDLC_ASSERT_IMPL(a_step_fills_slot, advance, ##1 out_valid_reg,
        "stepped item lost its result")

endmodule

>>> tb/sv/tb_password_door_lock_controller_unit.sv
// Self-checking testbench for the door lock controller: directed and random byte/tick
// streams, checked item by item against a behavioral lock model kept in this file.
// Depends on pdlc_pkg and password_door_lock_controller_unit.
module tb_password_door_lock_controller_unit;
    import pdlc_pkg::*;

    // Command field of an input item
    localparam logic IS_BYTE = 1'b0;
    localparam logic IS_TICK = 1'b1;

    localparam int LONG_STALL     = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SHOW_LIMIT     = 10;

    localparam cfg_t DEFAULT_CFG = '{RST_CHANGE_OPT, RST_OPEN_OPT, RST_END_MARKER,
                                     RST_MAX_ATT, RST_MOVE_TICKS, RST_HOLD_TICKS,
                                     RST_ALARM_TICKS};

    typedef struct packed {
        logic       is_tick;
        logic [7:0] rx_byte;
    } lock_item_t;

    // Lock state as the model sees it
    typedef struct packed {
        phase_t                  ph;
        logic [MAX_LEN-1:0][7:0] stored_key;
        logic [LEN_W-1:0]        stored_len;
        logic [LEN_W-1:0]        typed_len;
        logic                    typed_ok;
        logic [2:0]              fails;
        logic [7:0]              seconds;
    } lock_state_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;   // [7:0] rx_byte
    logic                 s_tuser   = 1'b0; // [0] command
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;          // [0] reply_valid, [1] reply_match,
                                            // [3:2] motor_drive, [4] buzzer_on,
                                            // [5] busy_res
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;

    lock_item_t  pending_inputs[$];
    result_t     expected_status[$];
    cfg_t        lock_cfg;
    lock_state_t pred_st;
    lock_state_t gen_st;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stall_requests = 0;
    int stall_served;
    int stall_left;
    int items_made;
    int bad_count      = 0;
    int quiet_cycles;

    password_door_lock_controller_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic lock_state_t lock_reset_state();
        lock_state_t st;
        st            = '0;
        st.ph         = PH_ENROLL_A;
        st.typed_ok   = 1'b1;
        return st;
    endfunction

    // Moves the lock one item forward and returns the status it shows afterwards
    function automatic result_t lock_advance(inout lock_state_t st, input cfg_t c,
                                             input logic is_tick, input logic [7:0] b);
        result_t    r;
        logic       reply;
        logic       ok;
        logic [7:0] limit;
        phase_t     next_ph;
        reply = 1'b0;
        ok    = 1'b0;
        if (is_tick)
        begin
            // timed phases count seconds; a zero limit ends on the first one
            case (st.ph)
                PH_DOOR_OPEN:
                begin
                    limit   = c.move_ticks;
                    next_ph = PH_DOOR_HOLD;
                end
                PH_DOOR_HOLD:
                begin
                    limit   = c.hold_ticks;
                    next_ph = PH_DOOR_CLOSE;
                end
                PH_DOOR_CLOSE:
                begin
                    limit   = c.move_ticks;
                    next_ph = PH_OPTION;
                end
                default:
                begin
                    limit   = c.alarm_ticks;
                    next_ph = PH_OPTION;
                end
            endcase
            if (st.ph >= PH_DOOR_OPEN)
            begin
                st.seconds = st.seconds + 8'd1;
                if (st.seconds >= limit)
                begin
                    st.ph      = next_ph;
                    st.seconds = '0;
                end
            end
        end
        else
        begin
            case (st.ph)
                PH_ENROLL_A:
                begin
                    if (b == c.end_marker)
                    begin
                        st.ph       = PH_ENROLL_B;
                        st.typed_len = '0;
                        st.typed_ok  = 1'b1;
                    end
                    else if (st.stored_len < MAX_LEN)
                    begin
                        st.stored_key[st.stored_len] = b;
                        st.stored_len = st.stored_len + 1'b1;
                    end
                end
                PH_ENROLL_B, PH_CHECK_CHANGE, PH_CHECK_OPEN:
                begin
                    if (b != c.end_marker)
                    begin
                        // bytes past the longest code are dropped
                        if (st.typed_len < MAX_LEN)
                        begin
                            if (st.typed_len >= st.stored_len ||
                                st.stored_key[st.typed_len] != b)
                                st.typed_ok = 1'b0;
                            st.typed_len = st.typed_len + 1'b1;
                        end
                    end
                    else
                    begin
                        reply = 1'b1;
                        ok    = st.typed_ok && (st.typed_len == st.stored_len);
                        // every outcome starts a fresh entry
                        st.typed_len = '0;
                        st.typed_ok  = 1'b1;
                        if (ok && st.ph == PH_CHECK_OPEN)
                        begin
                            st.ph      = PH_DOOR_OPEN;
                            st.seconds = '0;
                        end
                        else if (ok && st.ph == PH_ENROLL_B)
                            st.ph = PH_OPTION;
                        else if (ok || st.ph == PH_ENROLL_B)
                        begin
                            st.ph         = PH_ENROLL_A;
                            st.stored_len = '0;
                        end
                        else
                        begin
                            if (st.fails != ATT_SAT)
                                st.fails = st.fails + 3'd1;
                            if (st.fails >= c.max_attempts)
                            begin
                                st.ph      = PH_ALARM;
                                st.seconds = '0;
                            end
                        end
                    end
                end
                PH_OPTION:
                begin
                    st.fails     = '0;
                    st.typed_len = '0;
                    st.typed_ok  = 1'b1;
                    // change wins when both option codes are equal
                    if (b == c.change_option_code)
                        st.ph = PH_CHECK_CHANGE;
                    else if (b == c.open_option_code)
                        st.ph = PH_CHECK_OPEN;
                    else
                    begin
                        st.ph      = PH_ALARM;
                        st.seconds = '0;
                    end
                end
                default: ;
            endcase
        end
        r.reply_valid = reply;
        r.reply_match = reply & ok;
        r.motor_drive = (st.ph == PH_DOOR_OPEN)  ? MOTOR_OPEN :
                        (st.ph == PH_DOOR_CLOSE) ? MOTOR_CLOSE : MOTOR_STOP;
        r.buzzer_on   = (st.ph == PH_ALARM);
        r.busy_res    = (st.ph >= PH_DOOR_OPEN);
        return r;
    endfunction

    // Queue one item and track the lock it is aimed at; ignored items do not count
    task automatic push_item(input logic is_tick, input logic [7:0] b);
        lock_item_t it;
        if (is_tick == (gen_st.ph >= PH_DOOR_OPEN))
            items_made++;
        it.is_tick = is_tick;
        it.rx_byte = b;
        pending_inputs.push_back(it);
        void'(lock_advance(gen_st, lock_cfg, is_tick, b));
    endtask

    function automatic logic [7:0] key_byte();
        logic [7:0] v;
        do
            v = 8'($urandom_range(255));
        while (v == lock_cfg.end_marker);
        return v;
    endfunction

    // Mostly short codes, some empty, some longer up to full length, a few too long
    function automatic int key_len();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return 0;
        if (pick < 80)
            return $urandom_range(1, 6);
        if (pick < 92)
            return $urandom_range(7, MAX_LEN);
        return $urandom_range(MAX_LEN + 1, MAX_LEN + 4);
    endfunction

    // Enter the stored code, a near miss of it or random bytes, then the end marker
    task automatic push_entry(input lock_state_t snap, input bit good);
        int         n;
        int         i;
        int         k;
        logic [7:0] v;
        n = snap.stored_len;
        if (good)
        begin
            for (i = 0; i < n; i++)
                push_item(IS_BYTE, snap.stored_key[i]);
            if (n == MAX_LEN)
                repeat ($urandom_range(2)) push_item(IS_BYTE, key_byte());
        end
        else
        begin
            case ($urandom_range(3))
                0: repeat (key_len()) push_item(IS_BYTE, key_byte());
                1:
                    for (i = 0; i < n - 1; i++)
                        push_item(IS_BYTE, snap.stored_key[i]);
                2:
                begin
                    for (i = 0; i < n; i++)
                        push_item(IS_BYTE, snap.stored_key[i]);
                    push_item(IS_BYTE, key_byte());
                end
                default:
                begin
                    // one byte changed
                    if (n == 0)
                        push_item(IS_BYTE, key_byte());
                    k = $urandom_range(n > 0 ? n - 1 : 0);
                    for (i = 0; i < n; i++)
                    begin
                        v = snap.stored_key[i];
                        if (i == k)
                            do
                                v = snap.stored_key[i] ^ 8'($urandom_range(1, 255));
                            while (v == lock_cfg.end_marker);
                        push_item(IS_BYTE, v);
                    end
                end
            endcase
        end
        push_item(IS_BYTE, lock_cfg.end_marker);
    endtask

    // One well-formed step of use for the phase the lock is in, or a little noise
    task automatic random_session();
        lock_state_t snap;
        int          pick;
        snap = gen_st;
        pick = $urandom_range(99);
        if (pick < 4)
            repeat ($urandom_range(1, 4))
                push_item($urandom_range(1) == 1, 8'($urandom_range(255)));
        else
            case (snap.ph)
                PH_ENROLL_A:
                begin
                    repeat (key_len()) push_item(IS_BYTE, key_byte());
                    push_item(IS_BYTE, lock_cfg.end_marker);
                end
                PH_ENROLL_B, PH_CHECK_CHANGE, PH_CHECK_OPEN:
                    push_entry(snap, pick < 76);
                PH_OPTION:
                    if (pick < 48)
                        push_item(IS_BYTE, lock_cfg.change_option_code);
                    else if (pick < 92)
                        push_item(IS_BYTE, lock_cfg.open_option_code);
                    else
                        push_item(IS_BYTE, 8'($urandom_range(255)));
                default:
                    if (pick < 10)
                        push_item(IS_BYTE, 8'($urandom_range(255)));
                    else
                        push_item(IS_TICK, 8'($urandom_range(255)));
            endcase
    endtask

    task automatic make_items(input int n);
        items_made = 0;
        while (items_made < n)
            random_session();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_config(input cfg_t c);
        write_reg(REG_CHANGE_OPT, c.change_option_code);
        write_reg(REG_OPEN_OPT, c.open_option_code);
        write_reg(REG_END_MARKER, c.end_marker);
        write_reg(REG_MAX_ATT, {5'd0, c.max_attempts});
        write_reg(REG_MOVE_TICKS, c.move_ticks);
        write_reg(REG_HOLD_TICKS, c.hold_ticks);
        write_reg(REG_ALARM_TICKS, c.alarm_ticks);
        lock_cfg = c;
        @(negedge clk);
    endtask

    // Wait for every queued item to go in and every status to come back
    task automatic wait_drained();
        @(negedge clk);
        while (pending_inputs.size() != 0 || s_tvalid || expected_status.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic cfg_t small_config();
        cfg_t c;
        c.change_option_code = 8'($urandom_range(255));
        do
            c.open_option_code = 8'($urandom_range(255));
        while (c.open_option_code == c.change_option_code);
        c.end_marker   = 8'($urandom_range(255));
        c.max_attempts = 3'($urandom_range(1, 7));
        c.move_ticks   = 8'($urandom_range(1, 5));
        c.hold_ticks   = 8'($urandom_range(1, 4));
        c.alarm_ticks  = 8'($urandom_range(1, 6));
        return c;
    endfunction

    task automatic run_phase(input cfg_t c, input int send_pct, input int recv_pct,
                             input int n, input bit hold_off, input bit pause_midway);
        apply_config(c);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (hold_off)
            stall_requests++;
        if (pause_midway)
        begin
            make_items(n / 2);
            wait_drained();
            make_items(n - n / 2);
        end
        else
            make_items(n);
        wait_drained();
    endtask

    // Sender: next queued item once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin : input_driver
        lock_item_t it;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_inputs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                it = pending_inputs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= it.rx_byte;
                s_tuser  <= it.is_tick;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Predicts on accepted inputs, checks accepted status items, drives tready
    always @(posedge clk or negedge rst_n)
    begin : status_monitor
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            stall_served <= 0;
            stall_left   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_status.push_back(lock_advance(pred_st, lock_cfg, s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[5:0]);
                if (expected_status.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= SHOW_LIMIT)
                        $display("%0t: status item with none expected: tdata=%h",
                                 $time, m_tdata);
                end
                else
                begin
                    want = expected_status.pop_front();
                    if (got.reply_valid !== want.reply_valid ||
                        got.reply_match !== want.reply_match ||
                        got.motor_drive !== want.motor_drive ||
                        got.buzzer_on   !== want.buzzer_on   ||
                        got.busy_res    !== want.busy_res)
                    begin
                        bad_count++;
                        if (bad_count <= SHOW_LIMIT)
                        begin
                            $display("%0t: status mismatch (exp/got): reply %b/%b match %b/%b",
                                     $time, want.reply_valid, got.reply_valid,
                                     want.reply_match, got.reply_match);
                            $display("    motor %0d/%0d buzzer %b/%b busy %b/%b",
                                     want.motor_drive, got.motor_drive,
                                     want.buzzer_on, got.buzzer_on,
                                     want.busy_res, got.busy_res);
                        end
                    end
                end
            end
            // long hold-off on request, random stalls otherwise
            if (stall_requests != stall_served)
            begin
                stall_served <= stall_requests;
                stall_left   <= LONG_STALL;
                m_tready     <= 1'b0;
            end
            else
            begin
                if (stall_left != 0)
                    stall_left <= stall_left - 1;
                m_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: ends the run when no channel moves for too long
    always @(posedge clk or negedge rst_n)
    begin : watchdog
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                 (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved in %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus_plan
        cfg_t c;
        lock_cfg = DEFAULT_CFG;
        pred_st  = lock_reset_state();
        gen_st   = lock_reset_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: short timers, two attempts, default option and end codes
        c              = DEFAULT_CFG;
        c.max_attempts = 3'd2;
        c.move_ticks   = 8'd1;
        c.hold_ticks   = 8'd0;
        c.alarm_ticks  = 8'd1;
        apply_config(c);
        push_item(IS_TICK, 8'h00);                  // tick while idle
        push_item(IS_BYTE, RST_END_MARKER);         // empty code, twice
        push_item(IS_BYTE, RST_END_MARKER);
        push_item(IS_BYTE, 8'h00);                  // unknown option: alarm
        push_item(IS_BYTE, 8'hFF);                  // byte while busy
        push_item(IS_TICK, 8'hFF);
        push_item(IS_BYTE, RST_OPEN_OPT);
        push_item(IS_BYTE, 8'h00);                  // wrong, then right
        push_item(IS_BYTE, RST_END_MARKER);
        push_item(IS_BYTE, RST_END_MARKER);
        repeat (3) push_item(IS_TICK, 8'h5A);       // open, zero hold, close
        push_item(IS_BYTE, RST_CHANGE_OPT);
        push_item(IS_BYTE, RST_END_MARKER);
        push_item(IS_BYTE, 8'hFF);                  // enrollment entries differ
        push_item(IS_BYTE, RST_END_MARKER);
        push_item(IS_BYTE, 8'h00);
        push_item(IS_BYTE, RST_END_MARKER);
        push_item(IS_BYTE, 8'hFF);                  // new code accepted
        push_item(IS_BYTE, RST_END_MARKER);
        push_item(IS_BYTE, 8'hFF);
        push_item(IS_BYTE, RST_END_MARKER);
        push_item(IS_BYTE, RST_OPEN_OPT);           // two misses: reply and alarm
        push_item(IS_BYTE, RST_END_MARKER);
        push_item(IS_BYTE, 8'h00);
        push_item(IS_BYTE, RST_END_MARKER);
        push_item(IS_TICK, 8'h00);
        wait_drained();

        // Random phases
        run_phase(DEFAULT_CFG, 0, 0, 300, 1'b0, 1'b0);
        run_phase(small_config(), 58, 0, 300, 1'b0, 1'b0);
        run_phase(small_config(), 0, 58, 300, 1'b1, 1'b0);
        c = '{8'hFF, 8'hFE, 8'h00, 3'd7, 8'hFF, 8'hFF, 8'hFF};
        run_phase(c, 24, 24, 500, 1'b0, 1'b0);
        // equal option codes, zero attempts and zero timers
        c = '{8'h00, 8'h00, 8'hFF, 3'd0, 8'h00, 8'h00, 8'h00};
        run_phase(c, 0, 0, 250, 1'b0, 1'b0);
        run_phase(small_config(), 24, 24, 350, 1'b0, 1'b1);

        if (bad_count == 0 && expected_status.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/pdlc_pkg.sv
rtl/core/pdlc_fsm.sv
rtl/core/password_door_lock_controller_unit.sv
tb/sv/tb_password_door_lock_controller_unit.sv
